>>> hw/rtl/pinhole_point_projector_top_defines.svh
// Assertion macros shared by the projector RTL.
`ifndef PINHOLE_POINT_PROJECTOR_TOP_DEFINES_SVH
`define PINHOLE_POINT_PROJECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ppp_pkg.sv
`timescale 1ns / 1ps
package ppp_pkg;

  localparam int IN_W      = 24;  // input coordinate width, Q14.10
  localparam int OUT_W     = 24;  // output coordinate width, Q16.8
  localparam int CFG_W     = 60;  // configuration data width
  localparam int IDX_W     = 3;   // configuration index width
  localparam int E_W       = 20;  // packed matrix entry width
  localparam int P_W       = 25;  // flipped point coordinate
  localparam int S_W       = 47;  // R*p + t accumulator, 28 fraction bits
  localparam int C_W       = 30;  // camera-space coordinate, Q.10
  localparam int H_W       = 50;  // homogeneous image coordinate
  localparam int N_W       = 58;  // scaled dividend
  localparam int D_W       = 49;  // divisor magnitude
  localparam int DIV_STEPS = 24;  // quotient bits, one per stage
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int RND_SHIFT = 18;

  localparam logic [OUT_W-1:0] OUT_MAX     = 24'h7F_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN_MAG = 24'h80_0000;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_K0, REG_K1, REG_K2, REG_R0, REG_R1, REG_R2, REG_T, REG_FLIP
  } reg_idx_e;

  typedef logic signed [P_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [2:0][CFG_W-1:0] k;
    logic [2:0][CFG_W-1:0] r;
    logic [CFG_W-1:0]      t;
    logic                  flip;
  } cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] u;
    logic [OUT_W-1:0] v;
    logic             inv;
  } result_t;

  // Extract packed signed entry idx (0..2) of a register word.
  function automatic logic signed [E_W-1:0] entry(input logic [CFG_W-1:0] word,
                                                  input int idx);
    entry = word[idx*E_W +: E_W];
  endfunction

endpackage

>>> hw/rtl/ppp_fifo.sv
`timescale 1ns / 1ps
module ppp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/ppp_front.sv
`timescale 1ns / 1ps
module ppp_front import ppp_pkg::*; (
  input  logic            push_i,
  input  logic            q_full_i,
  input  logic [IN_W-1:0] point_x_i,
  input  logic [IN_W-1:0] point_y_i,
  input  logic [IN_W-1:0] point_z_i,
  input  cfg_t            cfg_i,
  output logic            q_push_o,
  output point_t          q_data_o
);

  coord_t ext_y;

  // A transaction enters the queue whenever there is room.
  assign q_push_o = push_i && !q_full_i;

  // Apply the axis flip; a widened negation is exact.
  assign ext_y        = coord_t'(signed'(point_y_i));
  assign q_data_o.x   = coord_t'(signed'(point_x_i));
  assign q_data_o.y   = cfg_i.flip ? -ext_y : ext_y;
  assign q_data_o.z   = -coord_t'(signed'(point_z_i));

endmodule

>>> hw/rtl/ppp_div.sv
`timescale 1ns / 1ps
module ppp_div import ppp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [H_W-1:0]   num_i,
  input  logic signed [H_W-1:0]   den_i,
  output logic [OUT_W-1:0]        q_o
);

  logic [N_W-1:0]       rem_q [DIV_STEPS+1];
  logic [D_W-1:0]       d_q   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
  logic                 neg_q [DIV_STEPS+1];
  logic                 sat_q [DIV_STEPS+1];

  logic [H_W-1:0] mag;
  logic [D_W-1:0] dd;
  logic [N_W-1:0] nn;

  // Setup: magnitude, rounding offset and overflow check.
  always_comb begin
    mag = num_i[H_W-1] ? H_W'(-num_i) : H_W'(num_i);
    dd  = D_W'(den_i);
    nn  = (N_W'(mag) << 8) + N_W'(dd >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= nn;
      d_q[0]   <= dd;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[H_W-1];
      sat_q[0] <= (nn >> DIV_STEPS) >= N_W'(dd);
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    localparam int B = DIV_STEPS - s;
    logic take;
    assign take = (rem_q[s-1] >> B) >= N_W'(d_q[s-1]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? rem_q[s-1] - (N_W'(d_q[s-1]) << B) : rem_q[s-1];
        quo_q[s] <= take ? (quo_q[s-1] | (DIV_STEPS'(1) << B)) : quo_q[s-1];
        d_q[s]   <= d_q[s-1];
        neg_q[s] <= neg_q[s-1];
        sat_q[s] <= sat_q[s-1];
      end
    end
  end

  // Sign and saturation.
  always_comb begin
    if (neg_q[DIV_STEPS]) begin
      if (sat_q[DIV_STEPS] || OUT_W'(quo_q[DIV_STEPS]) > OUT_MIN_MAG) begin
        q_o = OUT_MIN_MAG;
      end else begin
        q_o = -OUT_W'(quo_q[DIV_STEPS]);
      end
    end else begin
      if (sat_q[DIV_STEPS] || OUT_W'(quo_q[DIV_STEPS]) > OUT_MAX) begin
        q_o = OUT_MAX;
      end else begin
        q_o = OUT_W'(quo_q[DIV_STEPS]);
      end
    end
  end

endmodule

>>> hw/rtl/ppp_back.sv
`timescale 1ns / 1ps
module ppp_back import ppp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  input  point_t  in_data_i,
  output logic    in_pop_o,
  input  logic    out_full_i,
  output logic    out_valid_o,
  output result_t out_data_o
);

  localparam logic signed [S_W-1:0] C_RND = S_W'(1) << (RND_SHIFT - 1);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;
  logic vld_q [DIV_LAT];
  logic inv_q [DIV_LAT];

  logic signed [S_W-1:0] prod1_q [3][3];
  logic signed [C_W-1:0] c_q [3];
  logic signed [H_W-1:0] prod2_q [3][3];
  logic signed [H_W-1:0] h_q [3];
  logic signed [P_W-1:0] p [3];
  logic signed [S_W-1:0] s_sum [3];
  logic [OUT_W-1:0]      u_q, v_q;

  // The whole pipe advances unless the result queue is full.
  assign en       = !out_full_i;
  assign in_pop_o = en && in_valid_i;

  assign p[0] = in_data_i.x;
  assign p[1] = in_data_i.y;
  assign p[2] = in_data_i.z;

  // Valid bits of the arithmetic stages and the divider delay line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      vld_q[0] <= v4_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Rotation products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod1_q[r][k] <= S_W'(entry(cfg_i.r[r], k)) * S_W'(p[k]);
        end
      end
    end
  end

  // Add translation and round to Q.10.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s_sum[r] = prod1_q[r][0] + prod1_q[r][1] + prod1_q[r][2]
               + (S_W'(entry(cfg_i.t, r)) <<< RND_SHIFT) + C_RND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        c_q[r] <= C_W'(s_sum[r] >>> RND_SHIFT);
      end
    end
  end

  // Intrinsic products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod2_q[r][k] <= H_W'(entry(cfg_i.k[r], k)) * H_W'(c_q[k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        h_q[r] <= prod2_q[r][0] + prod2_q[r][1] + prod2_q[r][2];
      end
    end
  end

  // Depth test travels beside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q[0] <= h_q[2][H_W-1] || (h_q[2] == '0);
      for (int i = 1; i < DIV_LAT; i++) begin
        inv_q[i] <= inv_q[i-1];
      end
    end
  end

  ppp_div u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (h_q[0]),
    .den_i (h_q[2]),
    .q_o   (u_q)
  );

  ppp_div u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (h_q[1]),
    .den_i (h_q[2]),
    .q_o   (v_q)
  );

  // Invalid depth forces zero coordinates.
  assign out_valid_o    = vld_q[DIV_LAT-1];
  assign out_data_o.inv = inv_q[DIV_LAT-1];
  assign out_data_o.u   = inv_q[DIV_LAT-1] ? '0 : u_q;
  assign out_data_o.v   = inv_q[DIV_LAT-1] ? '0 : v_q;

endmodule

>>> hw/rtl/pinhole_point_projector_top.sv
`timescale 1ns / 1ps
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------
// point in  | push_i / full_o      | point_x_i, point_y_i, point_z_i
// result    | empty_o / pop_i      | image_u_o, image_v_o, invalid_o
// config    | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One point is accepted per cycle while full_o is low; throughput is set by the
// fully pipelined matrix stages and the two 24-stage restoring dividers.
// From accept to result visible a point passes the input queue, four
// multiply/add stages and 25 divider stages, the last of which writes
// the result queue.
// A full result queue stalls the whole arithmetic pipe; the input queue
// keeps accepting until it fills. Reset empties both queues and loads
// zero matrices with the y flip selected; z is always negated.
`include "pinhole_point_projector_top_defines.svh"
module pinhole_point_projector_top import ppp_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [IN_W-1:0]  point_x_i,
  input  logic [IN_W-1:0]  point_y_i,
  input  logic [IN_W-1:0]  point_z_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [OUT_W-1:0] image_u_o,
  output logic [OUT_W-1:0] image_v_o,
  output logic             invalid_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    q_push, q_full, q_empty, q_pop;
  point_t  q_wdata, q_rdata;
  logic    out_valid, out_full, out_push;
  result_t out_wdata, out_rdata;

  // Configuration register file.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_K0:   cfg_d.k[0] = cfg_data_i;
        REG_K1:   cfg_d.k[1] = cfg_data_i;
        REG_K2:   cfg_d.k[2] = cfg_data_i;
        REG_R0:   cfg_d.r[0] = cfg_data_i;
        REG_R1:   cfg_d.r[1] = cfg_data_i;
        REG_R2:   cfg_d.r[2] = cfg_data_i;
        REG_T:    cfg_d.t    = cfg_data_i;
        REG_FLIP: cfg_d.flip = cfg_data_i[0];
        default:  cfg_d      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_t'{k: '0, r: '0, t: '0, flip: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ppp_front u_front (
    .push_i    (push_i),
    .q_full_i  (q_full),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .cfg_i     (cfg_q),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  assign full_o = q_full;

  ppp_fifo #(
    .WIDTH ($bits(point_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  ppp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (!q_empty),
    .in_data_i   (q_rdata),
    .in_pop_o    (q_pop),
    .out_full_i  (out_full),
    .out_valid_o (out_valid),
    .out_data_o  (out_wdata)
  );

  assign out_push = out_valid && !out_full;

  ppp_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_rdata),
    .empty_o (empty_o)
  );

  assign image_u_o = out_rdata.u;
  assign image_v_o = out_rdata.v;
  assign invalid_o = out_rdata.inv;

  // Invalid results carry zero coordinates.
  `PPP_ASSERT_NOW(a_inv_zero, !empty_o && invalid_o, image_u_o == '0 && image_v_o == '0, "invalid result with nonzero coordinates")
  // The back end only takes from a nonempty queue.
  `PPP_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "back end popped an empty queue")
  // A finished result waiting on a full queue stays pending.
  `PPP_ASSERT_NEXT(a_stall_hold, out_valid && out_full, out_valid, "stalled result dropped")

endmodule
